// File: rtl/core/nsx_pkg.sv
// Shared types and constants for the nibble stego pixel extractor.
// No dependencies; imported by every module of the block.
package nsx_pkg;

    // Header delimiter codes (red nibble in the top four bits)
    localparam logic [11:0] CODE_WIDTH_DELIM  = 12'hAF5;
    localparam logic [11:0] CODE_HEIGHT_DELIM = 12'hFAF;
    localparam int unsigned CODE_BITS         = 12;

    // Dimension defaults and parameter defaults
    localparam int unsigned DEFAULT_DIM     = 100;
    localparam int unsigned DIM_BITS_DEF    = 16;
    localparam int unsigned HEADER_BITS_DEF = 24;

    // Fixed port field widths
    localparam int unsigned COLOR_BITS = 8;
    localparam int unsigned POS_BITS   = 16;
    localparam int unsigned IN_DATA_W  = 3 * COLOR_BITS;
    localparam int unsigned OUT_DATA_W = 3 * COLOR_BITS + 4 * POS_BITS;

    // One cover pixel request
    typedef struct packed {
        logic                  frame_start;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } pix_in_t;

    // One result request
    typedef struct packed {
        logic                  end_of_image;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [POS_BITS-1:0]   row;
        logic [POS_BITS-1:0]   column;
        logic [POS_BITS-1:0]   width;
        logic [POS_BITS-1:0]   height;
    } pix_out_t;

endpackage

// File: rtl/core/nsx_in_skid.sv
// Input register of the extractor: a two-entry skid stage with registered ready.
// Depends on nsx_pkg for the pixel request type.
module nsx_in_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  nsx_pkg::pix_in_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output nsx_pkg::pix_in_t out_item
);
    import nsx_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    pix_in_t main_reg, main_next;
    pix_in_t skid_reg, skid_next;
    logic    push, pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign pop       = main_valid_reg && out_ready;

    // Refill main from skid first, then from the incoming request
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next = in_item;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = in_item;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_item;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Hold control flags under reset; payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// File: rtl/core/nsx_decoder.sv
// Header parser, pixel counters and result register of the extractor.
// Depends on nsx_pkg for codes, defaults and request types.
module nsx_decoder #(
    parameter int unsigned DIM_BITS    = nsx_pkg::DIM_BITS_DEF,
    parameter int unsigned HEADER_BITS = nsx_pkg::HEADER_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  nsx_pkg::pix_in_t  in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output nsx_pkg::pix_out_t out_item
);
    import nsx_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    localparam logic [DIM_BITS-1:0] DIM_MAX   = {DIM_BITS{1'b1}};
    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(DEFAULT_DIM);

    phase_t                 phase_reg, phase_next, phase_cur;
    logic [HEADER_BITS-1:0] acc_reg, acc_next, acc_cur, acc_shift;
    logic                   ovf_reg, ovf_next, ovf_cur;
    logic [DIM_BITS-1:0]    width_reg, width_next, width_cur;
    logic [DIM_BITS-1:0]    height_reg, height_next, height_cur;
    logic [DIM_BITS-1:0]    row_reg, row_next, row_cur;
    logic [DIM_BITS-1:0]    col_reg, col_next, col_cur;
    logic                   out_valid_reg, out_valid_next;
    pix_out_t               out_reg, out_next;

    logic [3:0]             red_nib, green_nib, blue_nib;
    logic [CODE_BITS-1:0]   code;
    logic [DIM_BITS-1:0]    latch_val;
    logic [DIM_BITS:0]      col_plus;
    logic                   take;

    assign take      = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Start of frame restarts from the reset state before this pixel
    always_comb
    begin
        if (in_item.frame_start)
        begin
            phase_cur  = PH_HEADER;
            acc_cur    = '0;
            ovf_cur    = 1'b0;
            width_cur  = DIM_RESET;
            height_cur = DIM_RESET;
            row_cur    = '0;
            col_cur    = '0;
        end
        else
        begin
            phase_cur  = phase_reg;
            acc_cur    = acc_reg;
            ovf_cur    = ovf_reg;
            width_cur  = width_reg;
            height_cur = height_reg;
            row_cur    = row_reg;
            col_cur    = col_reg;
        end
    end

    // Code, header shift and saturated dimension value
    assign red_nib   = in_item.red[3:0];
    assign green_nib = in_item.green[3:0];
    assign blue_nib  = in_item.blue[3:0];
    assign code      = {red_nib, green_nib, blue_nib};
    assign acc_shift = (acc_cur << CODE_BITS) | HEADER_BITS'(code);
    assign latch_val = (ovf_cur || ((acc_cur >> DIM_BITS) != '0)) ? DIM_MAX
                                                                  : DIM_BITS'(acc_cur);
    assign col_plus  = {1'b0, col_cur} + {{DIM_BITS{1'b0}}, 1'b1};

    // Next state and result for the accepted pixel
    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (take)
        begin
            phase_next  = phase_cur;
            acc_next    = acc_cur;
            ovf_next    = ovf_cur;
            width_next  = width_cur;
            height_next = height_cur;
            row_next    = row_cur;
            col_next    = col_cur;
            out_valid_next = 1'b0;

            out_next.end_of_image = 1'b0;
            out_next.red          = {red_nib, 4'b0000};
            out_next.green        = {green_nib, 4'b0000};
            out_next.blue         = {blue_nib, 4'b0000};
            out_next.row          = POS_BITS'(row_cur);
            out_next.column       = POS_BITS'(col_cur);
            out_next.width        = POS_BITS'(width_cur);
            out_next.height       = POS_BITS'(height_cur);

            case (phase_cur)
                PH_HEADER:
                begin
                    if (code == CODE_HEIGHT_DELIM)
                    begin
                        height_next = latch_val;
                        phase_next  = PH_PIXELS;
                    end
                    else if (code == CODE_WIDTH_DELIM)
                    begin
                        width_next = latch_val;
                        acc_next   = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        if ((acc_cur >> (HEADER_BITS - CODE_BITS)) != '0)
                        begin
                            ovf_next = 1'b1;
                        end
                        acc_next = acc_shift;
                    end
                end
                PH_PIXELS:
                begin
                    if (code == CODE_HEIGHT_DELIM)
                    begin
                        out_next.end_of_image = 1'b1;
                        out_next.red          = '0;
                        out_next.green        = '0;
                        out_next.blue         = '0;
                        out_next.row          = '0;
                        out_next.column       = '0;
                        out_valid_next        = 1'b1;
                        phase_next            = PH_DONE;
                    end
                    else
                    begin
                        out_valid_next = (row_cur < height_cur) && (col_cur < width_cur);
                        // Advance position, saturating both counters
                        if (col_plus == {1'b0, width_cur})
                        begin
                            col_next = '0;
                            if (row_cur != DIM_MAX)
                            begin
                                row_next = row_cur + {{(DIM_BITS-1){1'b0}}, 1'b1};
                            end
                        end
                        else if (col_cur != DIM_MAX)
                        begin
                            col_next = col_plus[DIM_BITS-1:0];
                        end
                    end
                end
                default:
                begin
                    // Done phase and unused code: drop pixels until frame start
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            width_reg     <= DIM_RESET;
            height_reg    <= DIM_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// File: rtl/core/nibble_stego_pixel_extractor_core.sv
// Top level of the nibble stego pixel extractor: input skid stage and decoder.
// Depends on nsx_pkg, nsx_in_skid and nsx_decoder.
//
//  channel | direction | beat content
//  --------+-----------+------------------------------------------------
//  s_*     | in        | one cover pixel, tuser = frame start
//  m_*     | out       | one hidden pixel or, with tlast, the end marker
//
// One pixel is taken per cycle while the skid entry is free; each request passes
// through the input register and then the result register, and the header
// parser and counters update between them.
// Reset clears phase, header, counters and valid flags; dimensions return to 100.
// A stalled output holds its result; s_tready drops only once the skid entry fills.
module nibble_stego_pixel_extractor_core #(
    parameter int unsigned DIM_BITS    = nsx_pkg::DIM_BITS_DEF,
    parameter int unsigned HEADER_BITS = nsx_pkg::HEADER_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [nsx_pkg::IN_DATA_W-1:0]  s_tdata,  // red_in, green_in, blue_in
    input  logic                           s_tuser,  // frame_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // red_out, green_out, blue_out, pixel_row, pixel_column, image_width, image_height
    output logic [nsx_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast   // end_of_image
);
    import nsx_pkg::*;

    pix_in_t  in_item, dec_item;
    pix_out_t res_item;
    logic     dec_valid, dec_ready;

    // Unpack the pixel request
    assign in_item.frame_start = s_tuser;
    assign in_item.red         = s_tdata[COLOR_BITS-1:0];
    assign in_item.green       = s_tdata[2*COLOR_BITS-1:COLOR_BITS];
    assign in_item.blue        = s_tdata[3*COLOR_BITS-1:2*COLOR_BITS];

    nsx_in_skid u_in_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_item  (dec_item)
    );

    nsx_decoder #(
        .DIM_BITS    (DIM_BITS),
        .HEADER_BITS (HEADER_BITS)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_item   (dec_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (res_item)
    );

    // Pack the result request
    assign m_tlast = res_item.end_of_image;
    assign m_tdata = {res_item.height, res_item.width, res_item.column, res_item.row,
                      res_item.blue, res_item.green, res_item.red};

endmodule

// File: rtl/core/nsx_checker.sv
// Port-level checks for the nibble stego pixel extractor, bound to the top level.
// Depends on nsx_pkg and on nibble_stego_pixel_extractor_core.
module nsx_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [nsx_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [nsx_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                           m_tlast
);
    import nsx_pkg::*;

    logic [COLOR_BITS-1:0] red_out, green_out, blue_out;
    logic [POS_BITS-1:0]   row_out, col_out, width_out, height_out;
    logic                  in_seen;

    assign in_seen    = s_tvalid && s_tready && (s_tuser || !s_tuser) && (s_tdata == s_tdata);
    assign red_out    = m_tdata[COLOR_BITS-1:0];
    assign green_out  = m_tdata[2*COLOR_BITS-1:COLOR_BITS];
    assign blue_out   = m_tdata[3*COLOR_BITS-1:2*COLOR_BITS];
    assign row_out    = m_tdata[3*COLOR_BITS+POS_BITS-1:3*COLOR_BITS];
    assign col_out    = m_tdata[3*COLOR_BITS+2*POS_BITS-1:3*COLOR_BITS+POS_BITS];
    assign width_out  = m_tdata[3*COLOR_BITS+3*POS_BITS-1:3*COLOR_BITS+2*POS_BITS];
    assign height_out = m_tdata[3*COLOR_BITS+4*POS_BITS-1:3*COLOR_BITS+3*POS_BITS];

    // No result shows while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // End marker carries no pixel or position
    a_marker_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> red_out == '0 && green_out == '0 && blue_out == '0
                                && row_out == '0 && col_out == '0)
        else $error("end marker carries pixel data");

    // Hidden pixels sit inside the decoded image, nibbles in the upper half
    a_pixel_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> row_out < height_out && col_out < width_out
                                 && red_out[3:0] == 4'b0000 && green_out[3:0] == 4'b0000
                                 && blue_out[3:0] == 4'b0000)
        else $error("hidden pixel outside image or malformed");

    // The input channel only becomes blocked once an input has been accepted, or while it is already blocked
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(in_seen) || $past(!s_tready))
        else $error("input blocked without a preceding request");

endmodule

bind nibble_stego_pixel_extractor_core nsx_checker u_nsx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: bench/nibble_stego_pixel_extractor_core_tb.sv
// Testbench for nibble_stego_pixel_extractor_core: queued cover-pixel driver, result monitor
// and an in-bench decoder that predicts every hidden pixel and end marker.
// Depends on nsx_pkg and the RTL of the core.
`timescale 1ns / 100ps

module nibble_stego_pixel_extractor_core_tb;
    import nsx_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam logic [15:0] DIM_SAT = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_PIXELS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    // One queued cover pixel; hold asks the driver to wait for all results first
    typedef struct {
        pix_in_t px;
        bit      hold;
    } cover_req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // red_in, green_in, blue_in
    logic                  s_tuser;   // frame_start
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // red, green, blue, row, column, width, height
    logic                  m_tlast;   // end_of_image

    cover_req_t cover_q[$];
    pix_out_t   hidden_q[$];

    // Decoder state mirrored in the bench
    phase_t      dec_phase;
    logic [23:0] hdr_acc;
    bit          hdr_ovf;
    logic [15:0] img_w;
    logic [15:0] img_h;
    logic [15:0] row_cnt;
    logic [15:0] col_cnt;

    bit          req_taken;
    bit          hold_next;
    int unsigned cycles;
    int unsigned errors;
    int unsigned n_accepted;
    int unsigned n_pixels;
    int unsigned n_markers;
    int unsigned n_frames;

    nibble_stego_pixel_extractor_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit quiet_window();
        return (cycles >= 2000) && (cycles < 3200);
    endfunction

    function automatic logic [15:0] header_dim();
        if (hdr_ovf || (hdr_acc > {8'd0, DIM_SAT}))
            return DIM_SAT;
        return hdr_acc[15:0];
    endfunction

    // Decode one accepted cover pixel and queue the result it yields, if any
    task automatic decode_pixel(input pix_in_t px);
        logic [11:0] code;
        pix_out_t    res;
        begin
            if (px.frame_start)
            begin
                dec_phase = PH_HEADER;
                hdr_acc   = '0;
                hdr_ovf   = 1'b0;
                img_w     = 16'(DEFAULT_DIM);
                img_h     = 16'(DEFAULT_DIM);
                row_cnt   = '0;
                col_cnt   = '0;
            end
            code = {px.red[3:0], px.green[3:0], px.blue[3:0]};
            res  = '0;
            if (dec_phase == PH_HEADER)
            begin
                if (code == CODE_HEIGHT_DELIM)
                begin
                    img_h     = header_dim();
                    dec_phase = PH_PIXELS;
                end
                else if (code == CODE_WIDTH_DELIM)
                begin
                    img_w   = header_dim();
                    hdr_acc = '0;
                    hdr_ovf = 1'b0;
                end
                else
                begin
                    if (hdr_acc[23:12] != 12'd0)
                        hdr_ovf = 1'b1;
                    hdr_acc = {hdr_acc[11:0], code};
                end
            end
            else if (dec_phase == PH_PIXELS)
            begin
                if (code == CODE_HEIGHT_DELIM)
                begin
                    // End marker carries only the latched dimensions
                    res.end_of_image = 1'b1;
                    res.width        = img_w;
                    res.height       = img_h;
                    hidden_q.insert(hidden_q.size(), res);
                    dec_phase = PH_DONE;
                end
                else
                begin
                    if ((row_cnt < img_h) && (col_cnt < img_w))
                    begin
                        res.red    = {px.red[3:0], 4'd0};
                        res.green  = {px.green[3:0], 4'd0};
                        res.blue   = {px.blue[3:0], 4'd0};
                        res.row    = row_cnt;
                        res.column = col_cnt;
                        res.width  = img_w;
                        res.height = img_h;
                        hidden_q.insert(hidden_q.size(), res);
                    end
                    // Advance raster position, saturating both counters
                    if (({1'b0, col_cnt} + 17'd1) == {1'b0, img_w})
                    begin
                        col_cnt = '0;
                        if (row_cnt < DIM_SAT)
                            row_cnt = row_cnt + 16'd1;
                    end
                    else if (col_cnt < DIM_SAT)
                    begin
                        col_cnt = col_cnt + 16'd1;
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic add_raw(input bit fs, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
        cover_req_t req;
        begin
            req.px.frame_start = fs;
            req.px.red         = r;
            req.px.green       = g;
            req.px.blue        = b;
            req.hold           = hold_next;
            hold_next          = 1'b0;
            cover_q.insert(cover_q.size(), req);
        end
    endtask

    // Queue a pixel carrying a code in its low nibbles, random upper nibbles
    task automatic add_code(input bit fs, input logic [11:0] code);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
            r[3:0] = code[11:8];
            g[3:0] = code[7:4];
            b[3:0] = code[3:0];
            add_raw(fs, r, g, b);
        end
    endtask

    function automatic logic [11:0] plain_code();
        logic [11:0] c;
        do
            c = 12'($urandom_range(0, 4095));
        while ((c == CODE_WIDTH_DELIM) || (c == CODE_HEIGHT_DELIM));
        return c;
    endfunction

    task automatic build_stimulus();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        bit          junk;
        begin
            // Default width with a height-only header, byte extremes, done phase
            add_raw(1'b1, 8'hF0, 8'hF0, 8'hF2);
            add_code(1'b0, CODE_HEIGHT_DELIM);
            add_raw(1'b0, 8'hFF, 8'hFF, 8'hFF);
            add_raw(1'b0, 8'h00, 8'h00, 8'h00);
            add_raw(1'b0, 8'h5A, 8'hA5, 8'h3C);
            add_code(1'b0, CODE_HEIGHT_DELIM);
            add_raw(1'b0, 8'h12, 8'h34, 8'h56);
            // Width above the dimension range, height from an overflowed header
            add_code(1'b1, 12'h010);
            add_code(1'b0, 12'h000);
            add_code(1'b0, CODE_WIDTH_DELIM);
            add_code(1'b0, 12'h001);
            add_code(1'b0, 12'h002);
            add_code(1'b0, 12'h003);
            add_code(1'b0, CODE_HEIGHT_DELIM);
            add_code(1'b0, 12'h7E1);
            add_code(1'b0, CODE_HEIGHT_DELIM);
            // Empty header gives zero width: all pixels dropped
            add_code(1'b1, CODE_WIDTH_DELIM);
            add_code(1'b0, 12'h003);
            add_code(1'b0, CODE_HEIGHT_DELIM);
            add_code(1'b0, 12'h123);
            add_code(1'b0, 12'hABC);
            add_code(1'b0, CODE_HEIGHT_DELIM);
            // Zero height
            add_code(1'b1, CODE_HEIGHT_DELIM);
            add_code(1'b0, 12'h456);
            add_code(1'b0, CODE_HEIGHT_DELIM);

            // Random frames, mostly well formed with small dimensions
            hold_next = 1'b1;
            while (cover_q.size() < RANDOM_ITEMS)
            begin
                n_frames++;
                if ($urandom_range(0, 19) == 0)
                    hold_next = 1'b1;
                junk = ($urandom_range(0, 9) == 0);
                add_code($urandom_range(0, 9) != 0, junk ? plain_code() : 12'h000);
                if (junk && $urandom_range(0, 1))
                    add_code(1'b0, plain_code());
                if ($urandom_range(0, 15) == 0)
                    w = 32'(plain_code());
                else
                    w = $urandom_range(0, 6);
                h = $urandom_range(0, 5);
                add_code(1'b0, 12'(w));
                add_code(1'b0, CODE_WIDTH_DELIM);
                add_code(1'b0, 12'(h));
                add_code(1'b0, CODE_HEIGHT_DELIM);
                if (junk || (w > 8))
                    n = $urandom_range(1, 10);
                else
                    n = w * h + $urandom_range(0, 3);
                repeat (n)
                    add_code(1'b0, 12'($urandom_range(0, 4095)));
                // Most frames close with an end marker; the rest are cut short
                if ($urandom_range(0, 6) != 0)
                begin
                    add_code(1'b0, CODE_HEIGHT_DELIM);
                    repeat ($urandom_range(0, 2))
                        add_code(1'b0, 12'($urandom_range(0, 4095)));
                end
            end
        end
    endtask

    // Driver: present queued requests at the falling edge, idling at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || req_taken)
            begin
                req_taken = 1'b0;
                if ((cover_q.size() != 0)
                    && (quiet_window() || ($urandom_range(0, 99) >= 34))
                    && !(cover_q[0].hold && (hidden_q.size() != 0)))
                begin
                    s_tdata  <= {cover_q[0].px.blue, cover_q[0].px.green, cover_q[0].px.red};
                    s_tuser  <= cover_q[0].px.frame_start;
                    s_tvalid <= 1'b1;
                    void'(cover_q.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= quiet_window() || ($urandom_range(0, 99) >= 34);
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        pix_in_t  px;
        pix_out_t exp_r;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                px.frame_start = s_tuser;
                px.red         = s_tdata[7:0];
                px.green       = s_tdata[15:8];
                px.blue        = s_tdata[23:16];
                decode_pixel(px);
                req_taken = 1'b1;
                n_accepted++;
            end
            if (m_tvalid && m_tready)
            begin
                if (hidden_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h last %0b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    exp_r = hidden_q.pop_front();
                    if (m_tlast)
                        n_markers++;
                    else
                        n_pixels++;
                    check_field("end_of_image", 16'(exp_r.end_of_image), 16'(m_tlast));
                    check_field("red_out", 16'(exp_r.red), 16'(m_tdata[7:0]));
                    check_field("green_out", 16'(exp_r.green), 16'(m_tdata[15:8]));
                    check_field("blue_out", 16'(exp_r.blue), 16'(m_tdata[23:16]));
                    check_field("pixel_row", exp_r.row, m_tdata[39:24]);
                    check_field("pixel_column", exp_r.column, m_tdata[55:40]);
                    check_field("image_width", exp_r.width, m_tdata[71:56]);
                    check_field("image_height", exp_r.height, m_tdata[87:72]);
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        req_taken = 1'b0;
        hold_next = 1'b0;
        cycles    = 0;
        errors    = 0;
        n_accepted = 0;
        n_pixels  = 0;
        n_markers = 0;
        n_frames  = 0;
        dec_phase = PH_HEADER;
        hdr_acc   = '0;
        hdr_ovf   = 1'b0;
        img_w     = 16'(DEFAULT_DIM);
        img_h     = 16'(DEFAULT_DIM);
        row_cnt   = '0;
        col_cnt   = '0;
        build_stimulus();

        // Hold reset, then release it away from the rising edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Drain stimulus, then results, then let the pipeline settle
        while ((cover_q.size() != 0) || s_tvalid)
            @(posedge clk);
        while (hidden_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Fed %0d cover pixels over %0d random frames plus header corner cases;",
                 n_accepted, n_frames);
        $display("checked %0d hidden pixels and %0d end markers.", n_pixels, n_markers);
        if ((errors == 0) && (hidden_q.size() == 0))
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: nibble_stego_pixel_extractor_core.f
rtl/core/nsx_pkg.sv
rtl/core/nsx_in_skid.sv
rtl/core/nsx_decoder.sv
rtl/core/nibble_stego_pixel_extractor_core.sv
rtl/core/nsx_checker.sv
bench/nibble_stego_pixel_extractor_core_tb.sv
